// ----- hw/rtl/tgmm_pkg.sv -----
// shared types and constants for the talkgroup module map
`default_nettype none
package tgmm_pkg;
  localparam int unsigned TgW = 24;
  localparam int unsigned ModW = 5;
  localparam int unsigned TsW = 2;
  localparam int unsigned TtlW = 16;
  localparam int unsigned TimeW = 32;
  localparam logic [TsW-1:0] NoTimeslot = 2'd2;
  localparam logic [TsW-1:0] TsOne = 2'd1;
  localparam logic [15:0] RefreshReset = 16'd900;
  localparam logic [TimeW-1:0] TimeMax = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    CMD_ADD_STATIC  = 4'd0,
    CMD_ADD_DYNAMIC = 4'd1,
    CMD_REMOVE      = 4'd2,
    CMD_LOOKUP_TG   = 4'd3,
    CMD_LOOKUP_MOD  = 4'd4,
    CMD_REFRESH_TG  = 4'd5,
    CMD_REFRESH_MOD = 4'd6,
    CMD_TICK        = 4'd7,
    CMD_CLEAR       = 4'd8
  } cmd_t;

  typedef struct packed {
    logic [3:0]      cmd;
    logic [TgW-1:0]  talkgroup;
    logic [ModW-1:0] module_req;
    logic [TsW-1:0]  timeslot;
    logic [TtlW-1:0] ttl_seconds;
  } req_t;

  typedef struct packed {
    logic            ok;
    logic            found;
    logic [TgW-1:0]  out_talkgroup;
    logic [ModW-1:0] out_module;
    logic [TsW-1:0]  out_timeslot;
    logic            out_primary;
    logic            out_static;
    logic            last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;     // capture request, reset scan
    logic scan_step;    // examine current slot, advance
    logic tick_time;    // advance seconds counter
    logic do_clear;     // drop everything
    logic commit;       // apply post-scan action
    logic emit_purge;   // current slot expired: report and drop it
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;    // pointer is on the last slot
    logic purge_hit;    // current slot expired
  } dp_sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/tgmm_if.sv -----
// valid/ready channel interfaces for request and response
`default_nettype none
interface tgmm_req_if;
  logic valid;
  logic ready;
  tgmm_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tgmm_rsp_if;
  logic valid;
  logic ready;
  tgmm_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tgmm_datapath.sv -----
// table storage, scan pointer, time counter and result formation
`default_nettype none
module tgmm_datapath #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned MODULE_COUNT = 26
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_data,
  input  wire tgmm_pkg::req_t     req,
  input  wire tgmm_pkg::dp_cmd_t  ctl,
  output tgmm_pkg::dp_sts_t       sts,
  output tgmm_pkg::rsp_t          rsp
);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned MiW = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;

  logic [15:0] refresh_seconds;
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [tgmm_pkg::TgW-1:0] entry_talkgroup [TABLE_DEPTH];
  logic [tgmm_pkg::ModW-1:0] entry_module [TABLE_DEPTH];
  logic [tgmm_pkg::TsW-1:0] entry_timeslot [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_static;
  logic [TABLE_DEPTH-1:0] entry_primary;
  logic [tgmm_pkg::TimeW-1:0] entry_expiry [TABLE_DEPTH];
  logic [MODULE_COUNT-1:0] module_has_primary;
  logic [tgmm_pkg::TgW-1:0] module_primary_tg [MODULE_COUNT];
  logic [tgmm_pkg::TimeW-1:0] seconds_now;

  tgmm_pkg::req_t r;
  logic [IdxW-1:0] ptr;
  logic hit_any;
  logic [IdxW-1:0] hit_idx;
  logic free_any;
  logic [IdxW-1:0] free_idx;
  logic mod_hit;

  logic [IdxW-1:0] pidx;
  logic pv;
  logic mod_ok;
  logic [MiW-1:0] mi;
  logic [MiW-1:0] emi;
  logic [tgmm_pkg::TgW-1:0] key_tg;
  logic cur_match, cur_expired;
  logic [tgmm_pkg::TimeW:0] sum_ttl, sum_ref;
  logic [tgmm_pkg::TimeW-1:0] exp_ttl, exp_ref;
  logic [tgmm_pkg::TsW-1:0] ts_code;

  assign pidx = ptr;
  assign pv = entry_valid[pidx];
  assign mod_ok = {{(8 - tgmm_pkg::ModW){1'b0}}, r.module_req} < 8'(MODULE_COUNT);
  assign mi = r.module_req[MiW-1:0];
  assign emi = entry_module[pidx][MiW-1:0];
  assign key_tg = (r.cmd == tgmm_pkg::CMD_LOOKUP_MOD) ? module_primary_tg[mi] : r.talkgroup;
  assign cur_match = pv && entry_talkgroup[pidx] == key_tg;
  assign cur_expired = pv && !entry_static[pidx] && seconds_now >= entry_expiry[pidx];
  assign sum_ttl = {1'b0, seconds_now} + {{(tgmm_pkg::TimeW + 1 - tgmm_pkg::TtlW){1'b0}}, r.ttl_seconds};
  assign sum_ref = {1'b0, seconds_now} + {{(tgmm_pkg::TimeW - 15){1'b0}}, refresh_seconds};
  assign exp_ttl = sum_ttl[tgmm_pkg::TimeW] ? tgmm_pkg::TimeMax : sum_ttl[tgmm_pkg::TimeW-1:0];
  assign exp_ref = sum_ref[tgmm_pkg::TimeW] ? tgmm_pkg::TimeMax : sum_ref[tgmm_pkg::TimeW-1:0];
  assign ts_code = (r.timeslot == tgmm_pkg::TsOne) ? tgmm_pkg::TsOne : tgmm_pkg::NoTimeslot;

  assign sts.scan_done = (ptr == IdxW'(TABLE_DEPTH - 1));
  assign sts.purge_hit = cur_expired;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_seconds <= tgmm_pkg::RefreshReset;
      entry_valid <= '0;
      module_has_primary <= '0;
      seconds_now <= '0;
      ptr <= '0;
    end else begin
      if (cfg_we) begin
        refresh_seconds <= cfg_data;
      end
      if (ctl.load_req) begin
        r <= req;
        ptr <= '0;
        hit_any <= 1'b0;
        free_any <= 1'b0;
        mod_hit <= 1'b0;
        rsp <= '{ok: 1'b0, found: 1'b0, out_talkgroup: '0, out_module: '0,
                 out_timeslot: tgmm_pkg::NoTimeslot, out_primary: 1'b0,
                 out_static: 1'b0, last: 1'b1};
      end
      if (ctl.tick_time && seconds_now != tgmm_pkg::TimeMax) begin
        seconds_now <= seconds_now + 1'b1;
      end
      if (ctl.emit_purge) begin
        rsp <= '{ok: 1'b0, found: 1'b1, out_talkgroup: entry_talkgroup[pidx],
                 out_module: entry_module[pidx], out_timeslot: entry_timeslot[pidx],
                 out_primary: entry_primary[pidx], out_static: 1'b0,
                 last: 1'b0};
        entry_valid[pidx] <= 1'b0;
        if (entry_primary[pidx] && {3'b000, entry_module[pidx]} < 8'(MODULE_COUNT)) begin
          module_has_primary[emi] <= 1'b0;
        end
      end
      if (ctl.scan_step) begin
        if (!sts.scan_done) begin
          ptr <= ptr + 1'b1;
        end
        if (cur_match && !hit_any) begin
          hit_any <= 1'b1;
          hit_idx <= pidx;
        end
        if (!pv && !free_any) begin
          free_any <= 1'b1;
          free_idx <= pidx;
        end
        // refresh by module updates every matching dynamic entry as it goes
        if (r.cmd == tgmm_pkg::CMD_REFRESH_MOD && mod_ok && pv &&
            entry_module[pidx] == r.module_req && !entry_static[pidx]) begin
          mod_hit <= 1'b1;
          if (exp_ref > entry_expiry[pidx]) begin
            entry_expiry[pidx] <= exp_ref;
          end
        end
      end
      if (ctl.do_clear) begin
        entry_valid <= '0;
        module_has_primary <= '0;
        rsp.ok <= 1'b1;
      end
      if (ctl.commit) begin
        case (r.cmd)
          tgmm_pkg::CMD_ADD_STATIC, tgmm_pkg::CMD_ADD_DYNAMIC: begin
            if (mod_ok) begin
              if (hit_any) begin
                if (r.cmd == tgmm_pkg::CMD_ADD_DYNAMIC && !entry_static[hit_idx]) begin
                  entry_expiry[hit_idx] <= exp_ttl;
                  rsp.ok <= 1'b1;
                end
              end else if (free_any) begin
                entry_valid[free_idx] <= 1'b1;
                entry_talkgroup[free_idx] <= r.talkgroup;
                entry_module[free_idx] <= r.module_req;
                entry_timeslot[free_idx] <= ts_code;
                entry_static[free_idx] <= (r.cmd == tgmm_pkg::CMD_ADD_STATIC);
                entry_expiry[free_idx] <= (r.cmd == tgmm_pkg::CMD_ADD_STATIC) ? '0 : exp_ttl;
                entry_primary[free_idx] <= !module_has_primary[mi];
                if (!module_has_primary[mi]) begin
                  module_has_primary[mi] <= 1'b1;
                  module_primary_tg[mi] <= r.talkgroup;
                end
                rsp.ok <= 1'b1;
              end
            end
          end
          tgmm_pkg::CMD_REMOVE: begin
            if (hit_any && !entry_static[hit_idx]) begin
              entry_valid[hit_idx] <= 1'b0;
              if (entry_primary[hit_idx] &&
                  {3'b000, entry_module[hit_idx]} < 8'(MODULE_COUNT)) begin
                module_has_primary[entry_module[hit_idx][MiW-1:0]] <= 1'b0;
              end
              rsp.ok <= 1'b1;
            end
          end
          tgmm_pkg::CMD_LOOKUP_TG, tgmm_pkg::CMD_LOOKUP_MOD: begin
            if (hit_any && (r.cmd == tgmm_pkg::CMD_LOOKUP_TG ||
                            (mod_ok && module_has_primary[mi]))) begin
              rsp.found <= 1'b1;
              rsp.out_talkgroup <= entry_talkgroup[hit_idx];
              rsp.out_module <= entry_module[hit_idx];
              rsp.out_timeslot <= entry_timeslot[hit_idx];
              rsp.out_primary <= entry_primary[hit_idx];
              rsp.out_static <= entry_static[hit_idx];
            end
          end
          tgmm_pkg::CMD_REFRESH_TG: begin
            if (hit_any && !entry_static[hit_idx]) begin
              if (exp_ref > entry_expiry[hit_idx]) begin
                entry_expiry[hit_idx] <= exp_ref;
              end
              rsp.ok <= 1'b1;
            end
          end
          tgmm_pkg::CMD_REFRESH_MOD: begin
            rsp.ok <= mod_hit;
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tgmm_ctrl.sv -----
// sequencer: accepts a request, walks the table, hands out results
`default_nettype none
module tgmm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  tgmm_req_if.sink               req_ch,
  input  wire logic              rsp_ready,
  output logic                   rsp_valid,
  output logic                   rsp_last_set,
  input  wire logic [3:0]        cur_cmd,
  input  wire tgmm_pkg::dp_sts_t sts,
  output tgmm_pkg::dp_cmd_t      ctl
);
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_COMMIT, S_PURGE, S_EMIT, S_DONE
  } state_t;

  state_t state;
  logic purged;      // an expired entry is held in the result register
  logic final_emit;  // purge result waiting is the last of the tick

  assign req_ch.ready = (state == S_IDLE);
  logic req_fire;
  assign req_fire = req_ch.valid && req_ch.ready;

  always_comb begin
    ctl = '0;
    ctl.load_req = req_fire;
    ctl.tick_time = req_fire && req_ch.data.cmd == tgmm_pkg::CMD_TICK;
    ctl.do_clear = (state == S_COMMIT) && cur_cmd == tgmm_pkg::CMD_CLEAR;
    ctl.commit = (state == S_COMMIT);
    ctl.scan_step = (state == S_SCAN) || ((state == S_PURGE) && !sts.purge_hit);
    ctl.emit_purge = (state == S_PURGE) && sts.purge_hit && !purged;
  end

  assign rsp_valid = (state == S_EMIT) || (state == S_DONE);
  assign rsp_last_set = (state == S_DONE) || final_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      purged <= 1'b0;
      final_emit <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            purged <= 1'b0;
            state <= (req_ch.data.cmd == tgmm_pkg::CMD_TICK) ? S_PURGE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: state <= S_DONE;
        S_PURGE: begin
          // one expired entry is held back so the final one can carry last
          if (sts.purge_hit) begin
            if (purged) begin
              final_emit <= 1'b0;
              state <= S_EMIT;
            end else begin
              purged <= 1'b1;
            end
          end else if (sts.scan_done) begin
            if (purged) begin
              final_emit <= 1'b1;
              state <= S_EMIT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_EMIT: begin
          if (rsp_ready) begin
            final_emit <= 1'b0;
            purged <= 1'b0;
            state <= final_emit ? S_IDLE : S_PURGE;
          end
        end
        S_DONE: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ch.ready |-> !rsp_valid) else $error("ready while result pending");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !rsp_ready) |=> state == S_EMIT) else $error("emit dropped");
  a_one_ctl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.scan_step, ctl.commit, ctl.emit_purge})) else $error("ctl overlap");
endmodule
`default_nettype wire

// ----- hw/rtl/talkgroup_module_map_with_aging_top.sv -----
// top level of the talkgroup module map with aging
//  channel   dir  handshake            payload
//  req       in   req.valid/ready      cmd talkgroup module_req timeslot ttl_seconds
//  rsp       out  rsp.valid/ready      ok found out_* last
//  cfg       in   cfg_we               refresh_seconds
// tick: walks the table, dropping each expired dynamic entry and reporting it as a result
// other commands: one table slot examined per cycle
// reset synchronous; table valid bits cleared at once, no clearing pass
// a stalled result holds the sequencer; next request taken after the final transfer
`default_nettype none
module talkgroup_module_map_with_aging_top #(
  parameter int unsigned TABLE_DEPTH = 32,
  parameter int unsigned MODULE_COUNT = 26
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic [15:0] cfg_data,
  tgmm_req_if.sink        req,
  tgmm_rsp_if.source      rsp
);
  tgmm_pkg::dp_cmd_t ctl;
  tgmm_pkg::dp_sts_t sts;
  tgmm_pkg::rsp_t dp_rsp;
  tgmm_pkg::req_t cur;
  logic last_set;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cur <= req.data;
    end
  end

  tgmm_ctrl u_ctrl (
    .clk, .rst, .req_ch(req), .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
    .rsp_last_set(last_set), .cur_cmd(cur.cmd), .sts, .ctl
  );

  tgmm_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .MODULE_COUNT(MODULE_COUNT)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .req(req.data), .ctl, .sts, .rsp(dp_rsp)
  );

  always_comb begin
    rsp.data = dp_rsp;
    rsp.data.last = last_set;
  end
endmodule
`default_nettype wire
